### sv/tess_pkg.sv
`default_nettype none

package tess_pkg;

    // Default number of timer slots in the row.
    localparam int SLOTS_DEF = 8;

    localparam int ID_W    = 8;
    localparam int DELAY_W = 16;

    // Command codes of an input item.
    localparam logic [1:0] CMD_REGISTER   = 2'd0;
    localparam logic [1:0] CMD_TICK       = 2'd1;
    localparam logic [1:0] CMD_UNREGISTER = 2'd2;

    // Outcome codes of a result item.
    localparam logic [1:0] OUT_NONE    = 2'd0;
    localparam logic [1:0] OUT_FIRED   = 2'd1;
    localparam logic [1:0] OUT_DEFAULT = 2'd2;
    localparam logic [1:0] OUT_FULL    = 2'd3;

    // Input item.
    typedef struct packed {
        logic [1:0]         command;
        logic [ID_W-1:0]    event_id;
        logic [DELAY_W-1:0] delay;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic [1:0]      outcome;
        logic [ID_W-1:0] fired_id;
    } t_res_item;

    // Operation carried by a wave along the slot row.
    typedef enum logic [1:0] {
        OP_REGISTER,
        OP_TICK,
        OP_CLEAR
    } t_op;

    // Wave handed from one slot cell to the next.
    typedef struct packed {
        logic               active;
        t_op                op;
        logic [ID_W-1:0]    id;
        logic [DELAY_W-1:0] delay;
        logic               hit;
    } t_wave;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_CLEAR
    } t_state;

endpackage

`default_nettype wire

### sv/tess_cell.sv
`default_nettype none

// One timer slot. It acts on the wave passing through it and registers the
// wave for the next cell.
module tess_cell (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  tess_pkg::t_wave i_wave,
    output tess_pkg::t_wave o_wave
);

    logic                         r_valid;
    logic                         n_valid;
    logic [tess_pkg::ID_W-1:0]    r_event;
    logic [tess_pkg::ID_W-1:0]    n_event;
    logic [tess_pkg::DELAY_W-1:0] r_count;
    logic [tess_pkg::DELAY_W-1:0] n_count;
    tess_pkg::t_wave              r_wave;
    tess_pkg::t_wave              n_wave;

    // Slot update and wave modification.
    always_comb begin
        n_valid = r_valid;
        n_event = r_event;
        n_count = r_count;
        n_wave  = i_wave;
        if (i_wave.active) begin
            case (i_wave.op)
                tess_pkg::OP_REGISTER: begin
                    // The first free slot takes the new event.
                    if (!i_wave.hit && !r_valid) begin
                        n_valid     = 1'b1;
                        n_event     = i_wave.id;
                        n_count     = i_wave.delay;
                        n_wave.hit  = 1'b1;
                    end
                end
                tess_pkg::OP_TICK: begin
                    // Count down until the first expired slot; it fires.
                    if (!i_wave.hit && r_valid) begin
                        if (r_count != '0) begin
                            n_count = r_count - 1'b1;
                        end else begin
                            n_wave.hit = 1'b1;
                            n_wave.id  = r_event;
                        end
                    end
                end
                tess_pkg::OP_CLEAR: begin
                    if (r_valid && (r_event == i_wave.id)) begin
                        n_valid = 1'b0;
                    end
                end
                default: begin
                    n_wave.active = 1'b0;
                end
            endcase
        end
    end

    // Slot and wave registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= 1'b0;
            r_wave.active <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_wave  <= n_wave;
        end
        r_event <= n_event;
        r_count <= n_count;
    end

    assign o_wave = r_wave;

endmodule

`default_nettype wire

### sv/tess_ctrl.sv
`default_nettype none

// Sequencer: launches waves into the slot row, collects them at its end and
// forms the result item. Also holds the default id register.
module tess_ctrl (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         start,
    input  tess_pkg::t_in_item          i_item,
    output logic                        busy,
    input  wire                         i_cfg_valid,
    input  wire [tess_pkg::ID_W-1:0]    i_cfg_data,
    output logic                        o_cfg_ready,
    output tess_pkg::t_wave             o_launch,
    input  tess_pkg::t_wave             i_return,
    output logic                        o_res_valid,
    output tess_pkg::t_res_item         o_res
);

    tess_pkg::t_state          r_state;
    tess_pkg::t_state          n_state;
    tess_pkg::t_wave           r_launch;
    tess_pkg::t_wave           n_launch;
    logic                      r_res_valid;
    logic                      n_res_valid;
    tess_pkg::t_res_item       r_res;
    tess_pkg::t_res_item       n_res;
    logic [tess_pkg::ID_W-1:0] r_default_id;

    // Configuration is always writable.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_id <= '0;
        end else if (i_cfg_valid) begin
            r_default_id <= i_cfg_data;
        end
    end

    // Next state, launches and results.
    always_comb begin
        n_state         = r_state;
        n_launch        = r_launch;
        n_launch.active = 1'b0;
        n_res_valid     = 1'b0;
        n_res           = r_res;
        unique case (r_state)
            tess_pkg::S_IDLE: begin
                if (start) begin
                    n_launch.active = 1'b1;
                    n_launch.id     = i_item.event_id;
                    n_launch.delay  = i_item.delay;
                    n_launch.hit    = 1'b0;
                    n_state         = tess_pkg::S_SCAN;
                    case (i_item.command)
                        tess_pkg::CMD_REGISTER:   n_launch.op = tess_pkg::OP_REGISTER;
                        tess_pkg::CMD_TICK:       n_launch.op = tess_pkg::OP_TICK;
                        tess_pkg::CMD_UNREGISTER: n_launch.op = tess_pkg::OP_CLEAR;
                        default: begin
                            // Unused command: answer at once, touch nothing.
                            n_launch.active  = 1'b0;
                            n_launch.op      = tess_pkg::OP_CLEAR;
                            n_state          = tess_pkg::S_IDLE;
                            n_res_valid      = 1'b1;
                            n_res.outcome    = tess_pkg::OUT_NONE;
                            n_res.fired_id   = '0;
                        end
                    endcase
                end
            end
            tess_pkg::S_SCAN: begin
                if (i_return.active) begin
                    n_state        = tess_pkg::S_IDLE;
                    n_res_valid    = 1'b1;
                    n_res.fired_id = '0;
                    n_res.outcome  = tess_pkg::OUT_NONE;
                    case (i_return.op)
                        tess_pkg::OP_REGISTER: begin
                            if (!i_return.hit) begin
                                n_res.outcome = tess_pkg::OUT_FULL;
                            end
                        end
                        tess_pkg::OP_TICK: begin
                            if (i_return.hit) begin
                                // A slot fired: sweep out every slot with its id.
                                n_res_valid     = 1'b0;
                                n_state         = tess_pkg::S_CLEAR;
                                n_launch.active = 1'b1;
                                n_launch.op     = tess_pkg::OP_CLEAR;
                                n_launch.id     = i_return.id;
                                n_launch.hit    = 1'b0;
                            end else begin
                                n_res.outcome  = tess_pkg::OUT_DEFAULT;
                                n_res.fired_id = r_default_id;
                            end
                        end
                        default: begin
                            n_res.outcome = tess_pkg::OUT_NONE;
                        end
                    endcase
                end
            end
            tess_pkg::S_CLEAR: begin
                if (i_return.active) begin
                    n_state        = tess_pkg::S_IDLE;
                    n_res_valid    = 1'b1;
                    n_res.outcome  = tess_pkg::OUT_FIRED;
                    n_res.fired_id = i_return.id;
                end
            end
            default: begin
                n_state = tess_pkg::S_IDLE;
            end
        endcase
    end

    // State, launch and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= tess_pkg::S_IDLE;
            r_launch.active <= 1'b0;
            r_res_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_launch    <= n_launch;
            r_res_valid <= n_res_valid;
        end
        r_res <= n_res;
    end

    assign busy        = (r_state != tess_pkg::S_IDLE);
    assign o_launch    = r_launch;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

`default_nettype wire

### sv/tick_event_slot_scheduler_top.sv
`default_nettype none

// Table of SLOTS one-shot timer slots built as a row of cells. Each item is
// carried as a wave through the row, one cell per clock. Register and
// unregister items and ticks where nothing fires take one pass: the result
// strobe is registered as the wave leaves the last cell. A tick that fires
// a slot adds a second pass that clears every slot with the fired id. Unused
// command codes answer without a pass, registered at the accepting edge.
// busy is high while a pass runs and falls as the result is registered, so
// the next item can be started in the cycle of the result strobe. The result
// is shown for exactly one cycle on o_res_valid and cannot be held off; the
// receiver must take it then. The default id may be written at any time the
// block is idle; o_cfg_ready is always high.
module tick_event_slot_scheduler_top #(
    parameter int SLOTS = tess_pkg::SLOTS_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         start,
    input  tess_pkg::t_in_item          i_item,
    output logic                        busy,
    input  wire                         i_cfg_valid,
    input  wire [tess_pkg::ID_W-1:0]    i_cfg_data,
    output logic                        o_cfg_ready,
    output logic                        o_res_valid,
    output tess_pkg::t_res_item         o_res
);

    tess_pkg::t_wave w_chain [SLOTS+1];

    // Sequencer.
    tess_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_item      (i_item),
        .busy        (busy),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_launch    (w_chain[0]),
        .i_return    (w_chain[SLOTS]),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    // Row of slot cells, lowest index first in scan order.
    for (genvar g = 0; g < SLOTS; g++) begin : g_slot
        tess_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_wave  (w_chain[g]),
            .o_wave  (w_chain[g+1])
        );
    end

endmodule

`default_nettype wire
